>>> src/zbsf_pkg.sv
// Shared types and constants for the z-buffer span fill block.
package zbsf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned Z_FRAC_BITS = 8;

  localparam int unsigned FW_W = 10;  // frame_width register
  localparam int unsigned FH_W = 9;   // frame_height register
  localparam int unsigned CFG_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd512;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_DEPTH_PRESENT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPAN  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Control strobes from the sequencer to the frame memory
  typedef struct packed {
    logic color_we;
    logic depth_we;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> src/zbsf_frame_mem.sv
// Color and depth stores: one write port and one registered read port each.
module zbsf_frame_mem import zbsf_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_color,
  input  logic [15:0]   wr_depth,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_color,
  output logic [15:0]   rd_depth
);

  logic [15:0] color_mem [DEPTH];
  logic [15:0] depth_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.color_we) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (ctl.depth_we) begin
      depth_mem[wr_addr] <= wr_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_color <= color_mem[rd_addr];
      rd_depth <= depth_mem[rd_addr];
    end
  end

endmodule

>>> src/zbuffer_span_fill_top.sv
// Top level: command sequencer, z stepper and depth compare around the frame memory.
//
//  channel | ports                   | payload
//  --------+-------------------------+------------------------------------------
//  input   | in_tvalid/in_tready     | tuser: cmd; tdata: span/read/clear fields
//  result  | out_tvalid/out_tready   | tdata: read_color, read_depth, pixels_written
//  config  | cfg_we/cfg_index        | cfg_wdata: frame_width/height, depth_present
//
//  One request at a time; in_tready is low from acceptance until its result is
//  loaded into the output register. A span walks from x_start to its clipped end,
//  one pixel a cycle through the read/compare/write pipe of the memory port.
//  A clear writes one store entry a cycle. An empty span, a no-op, or a span or
//  read off the frame, goes from setup straight to done.
//  Reset restores the registers only; store contents are undefined until written.
//  A stalled result holds in the output register while the sequencer waits.
module zbuffer_span_fill_top import zbsf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [7:0] row, [16:8] x_start, [26:17] x_end, [42:27] fill_color,
  // [58:43] clear_depth, [90:59] z_start, [122:91] z_step,
  // [123] depth_test, [124] depth_write, [127:125] zero
  input  logic [127:0]         in_tdata,
  // [1:0] cmd
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] read_color, [31:16] read_depth, [41:32] pixels_written, [47:42] zero
  output logic [47:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW0   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW0   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XCW   = (XW0 > FW_W) ? XW0 : FW_W;
  localparam int unsigned YCW   = (YW0 > FH_W) ? YW0 : FH_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SETUP  = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_SPAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            depth_present_r;

  // latched request
  cmd_t         cmd_r;
  logic [7:0]   row_r;
  logic [9:0]   x_end_r;
  logic [15:0]  fill_color_r;
  logic [15:0]  clear_depth_r;
  logic [31:0]  z_step_r;
  logic         depth_test_r;
  logic         depth_write_r;

  // walk counters
  logic [XCW-1:0] x_r;
  logic [YCW-1:0] y_r;
  logic [AW-1:0]  base_r;
  logic [31:0]    z_r;

  // compare stage
  logic           valid_b_r;
  logic [31:0]    z_b_r;
  logic [AW-1:0]  addr_b_r;

  // result
  logic [15:0] res_color_r;
  logic [15:0] res_depth_r;
  logic [9:0]  count_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic [XCW-1:0] w_act, span_end, x_inc;
  logic [YCW-1:0] h_act;
  logic           row_ok;
  logic           tested;
  logic [23:0]    zi;
  logic           pass;
  logic [15:0]    depth_wb;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [15:0]    wr_color, wr_depth;
  logic [15:0]    rd_color, rd_depth;
  mem_ctl_t       ctl;
  logic           in_fire, out_load;

  assign w_act = (XCW'(frame_width_r) > XCW'(MAX_WIDTH)) ?
                 XCW'(MAX_WIDTH) : XCW'(frame_width_r);
  assign h_act = (YCW'(frame_height_r) > YCW'(MAX_HEIGHT)) ?
                 YCW'(MAX_HEIGHT) : YCW'(frame_height_r);
  assign span_end = (XCW'(x_end_r) < w_act) ? XCW'(x_end_r) : w_act;
  assign row_ok = YCW'(row_r) < h_act;
  assign tested = depth_test_r & depth_present_r;
  assign x_inc  = x_r + XCW'(1);

  // Compare unit: integer part of z against the stored depth
  assign zi       = z_b_r[31:Z_FRAC_BITS];
  assign pass     = !tested || ($signed({zi[23], zi}) <= $signed({9'd0, rd_depth}));
  assign depth_wb = zi[23] ? 16'd0 : zi[15:0];

  assign rd_addr = base_r + AW'(x_r);
  assign wr_addr = (state_r == S_CLEAR) ? rd_addr : addr_b_r;
  assign wr_color = fill_color_r;
  assign wr_depth = (state_r == S_CLEAR) ? clear_depth_r : depth_wb;

  always_comb begin
    ctl = '0;
    if (state_r == S_CLEAR) begin
      ctl.color_we = 1'b1;
      ctl.depth_we = depth_present_r;
    end else if (valid_b_r) begin
      ctl.color_we = pass;
      ctl.depth_we = pass & tested & depth_write_r;
    end
    ctl.rd_en = (state_r == S_SPAN) ||
                ((state_r == S_SETUP) && (cmd_r == CMD_READ));
  end

  zbsf_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_color (wr_color),
    .wr_depth (wr_depth),
    .rd_addr  (rd_addr),
    .rd_color (rd_color),
    .rd_depth (rd_depth)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        case (cmd_r)
          CMD_CLEAR: state_nxt = (w_act == '0 || h_act == '0) ? S_DONE : S_CLEAR;
          CMD_SPAN:  state_nxt = (row_ok && x_r < span_end) ? S_SPAN : S_DONE;
          CMD_READ:  state_nxt = (row_ok && x_r < w_act) ? S_RDWAIT : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: begin
        if (x_inc == w_act && y_r + YCW'(1) == h_act) state_nxt = S_DONE;
      end
      S_SPAN: begin
        if (x_inc == span_end) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      depth_present_r <= 1'b1;
      valid_b_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_b_r <= (state_r == S_SPAN);
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[FW_W-1:0];
          REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[FH_W-1:0];
          REG_DEPTH_PRESENT: depth_present_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r         <= cmd_t'(in_tuser);
      row_r         <= in_tdata[7:0];
      x_r           <= XCW'(in_tdata[16:8]);
      x_end_r       <= in_tdata[26:17];
      fill_color_r  <= in_tdata[42:27];
      clear_depth_r <= in_tdata[58:43];
      z_r           <= in_tdata[90:59];
      z_step_r      <= in_tdata[122:91];
      depth_test_r  <= in_tdata[123];
      depth_write_r <= in_tdata[124];
      base_r        <= AW'(AW'(in_tdata[7:0]) * AW'(MAX_WIDTH));
      y_r           <= '0;
      res_color_r   <= '0;
      res_depth_r   <= '0;
      count_r       <= '0;
    end

    case (state_r)
      S_SETUP: begin
        if (cmd_r == CMD_CLEAR) begin
          base_r <= '0;
          x_r    <= '0;
        end
      end
      S_CLEAR: begin
        // advance along the row, wrap to the next row base at the active width
        if (x_inc == w_act) begin
          x_r    <= '0;
          y_r    <= y_r + YCW'(1);
          base_r <= base_r + AW'(MAX_WIDTH);
        end else begin
          x_r <= x_inc;
        end
      end
      S_SPAN: begin
        z_b_r    <= z_r;
        addr_b_r <= rd_addr;
        x_r      <= x_inc;
        z_r      <= z_r + z_step_r;
      end
      S_RDWAIT: begin
        res_color_r <= rd_color;
        res_depth_r <= depth_present_r ? rd_depth : 16'd0;
      end
      default: ;
    endcase

    if (valid_b_r && pass) begin
      count_r <= count_r + 10'd1;
    end

    if (out_load) begin
      out_data_r <= {6'd0, count_r, res_depth_r, res_color_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_idle_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !valid_b_r)
    else $error("pixel in flight while idle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !(ctl.color_we || ctl.depth_we))
    else $error("store written outside a command");

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SETUP))
    else $error("accepted request did not enter setup");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_DONE) && !valid_b_r)
    else $error("span drain did not finish");

  a_span_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPAN) |-> (x_r < span_end))
    else $error("span walked past its clipped end");
`endif

endmodule
